[hw/rtl/gpde_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph point delta encoder package
// Shared types and constants for the glyph point delta encoder.
// ----------------------------------------------------------------------------
package gpde_pkg;

  localparam int COORD_W = 16;

  // Bounding box restart values: empty box
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  // Largest magnitude carried in the one-byte form
  localparam logic signed [COORD_W:0] SHORT_LIMIT = 17'sd255;

  // Glyph flag bits
  localparam logic [7:0] FLAG_ON_CURVE = 8'h01;
  localparam logic [7:0] FLAG_X_SHORT  = 8'h02;
  localparam logic [7:0] FLAG_Y_SHORT  = 8'h04;
  localparam logic [7:0] FLAG_X_SAME   = 8'h10;
  localparam logic [7:0] FLAG_Y_SAME   = 8'h20;

  // Delta byte counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      on_curve;
    logic                      first_point;
  } point_t;

  typedef struct packed {
    logic [7:0]                flag_byte;
    logic [1:0]                x_byte_count;
    logic [7:0]                x_first_byte;
    logic [7:0]                x_second_byte;
    logic [1:0]                y_byte_count;
    logic [7:0]                y_first_byte;
    logic [7:0]                y_second_byte;
    logic signed [COORD_W-1:0] box_x_min;
    logic signed [COORD_W-1:0] box_y_min;
    logic signed [COORD_W-1:0] box_x_max;
    logic signed [COORD_W-1:0] box_y_max;
  } code_t;

  // Per-axis view of stored state as seen by the current point
  typedef struct packed {
    logic signed [COORD_W-1:0] base;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } axis_view_t;

  // Encoded form of one delta
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       is_short;
    logic       is_same;
  } delta_code_t;

endpackage

[hw/rtl/gpde_channels.sv]
// ----------------------------------------------------------------------------
// Glyph point delta encoder channels
// Valid/ready stream interfaces for points in and encoded points out.
// ----------------------------------------------------------------------------
interface gpde_point_if;
  logic            valid;
  logic            ready;
  gpde_pkg::point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gpde_code_if;
  logic            valid;
  logic            ready;
  gpde_pkg::code_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/glyph_point_delta_encoder.sv]
// ----------------------------------------------------------------------------
// Glyph point delta encoder
// Encodes outline points into glyph flag bytes, delta bytes and a running box.
// ----------------------------------------------------------------------------
// Usage:
//   in_point  : valid/ready channel, one outline point per transfer
//               (x, y, on-curve mark, first-of-glyph mark).
//   out_code  : valid/ready channel, one encoded point per transfer: flag
//               byte, x and y delta bytes with counts, running bounding box.
//   The point is held in the input register, then the delta, flag and box
//   logic feeds the result register, which drives the output transfer.
//   Throughput is one point per cycle while the receiver does not stall;
//   the previous-point and box registers update as a point leaves the
//   input register, so back-to-back points chain through them without
//   bubbles.
//   Reset clears both stage valid flags, sets the previous point to zero and
//   the box to empty, so a stream that opens without a first-point mark
//   starts from the origin.
//   When the receiver stalls, the result register holds its transfer, the
//   input register fills behind it, and in_point.ready drops once both are
//   full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module glyph_point_delta_encoder (
  input  logic        clk,
  input  logic        rst_n,
  gpde_point_if.sink  in_point,
  gpde_code_if.source out_code
);
  import gpde_pkg::*;

  // Stage 1: input register
  logic   s1_valid_r, s1_valid_nxt;
  point_t s1_data_r;

  // Stage 2: result register
  logic   s2_valid_r, s2_valid_nxt;
  code_t  s2_data_r, s2_data_nxt;

  logic s2_load;
  logic s1_load;

  axis_view_t  x_view, y_view;
  delta_code_t x_code, y_code;

  // Advance a stage when its register is empty or drains this cycle
  assign s2_load = s1_valid_r && (!s2_valid_r || out_code.ready);
  assign s1_load = in_point.valid && in_point.ready;

  assign in_point.ready = !s1_valid_r || s2_load;

  assign s1_valid_nxt = s1_load || (s1_valid_r && !s2_load);
  assign s2_valid_nxt = s2_load || (s2_valid_r && !out_code.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_point.data;
    end
    if (s2_load) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  // Per-axis origin and box; state commits when the point moves to stage 2
  gpde_axis_state u_x_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s2_load),
    .first_point (s1_data_r.first_point),
    .coord       (s1_data_r.point_x),
    .view        (x_view)
  );

  gpde_axis_state u_y_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s2_load),
    .first_point (s1_data_r.first_point),
    .coord       (s1_data_r.point_y),
    .view        (y_view)
  );

  gpde_delta_coder u_x_coder (
    .cur  (s1_data_r.point_x),
    .base (x_view.base),
    .code (x_code)
  );

  gpde_delta_coder u_y_coder (
    .cur  (s1_data_r.point_y),
    .base (y_view.base),
    .code (y_code)
  );

  // Assemble the flag byte and the result
  always_comb begin
    s2_data_nxt.flag_byte = (s1_data_r.on_curve ? FLAG_ON_CURVE : 8'h00)
                          | (x_code.is_short    ? FLAG_X_SHORT  : 8'h00)
                          | (y_code.is_short    ? FLAG_Y_SHORT  : 8'h00)
                          | (x_code.is_same     ? FLAG_X_SAME   : 8'h00)
                          | (y_code.is_same     ? FLAG_Y_SAME   : 8'h00);
    s2_data_nxt.x_byte_count  = x_code.count;
    s2_data_nxt.x_first_byte  = x_code.first_byte;
    s2_data_nxt.x_second_byte = x_code.second_byte;
    s2_data_nxt.y_byte_count  = y_code.count;
    s2_data_nxt.y_first_byte  = y_code.first_byte;
    s2_data_nxt.y_second_byte = y_code.second_byte;
    s2_data_nxt.box_x_min     = x_view.lo;
    s2_data_nxt.box_y_min     = y_view.lo;
    s2_data_nxt.box_x_max     = x_view.hi;
    s2_data_nxt.box_y_max     = y_view.hi;
  end

  assign out_code.valid = s2_valid_r;
  assign out_code.data  = s2_data_r;

endmodule

[hw/rtl/gpde_delta_coder.sv]
// ----------------------------------------------------------------------------
// Glyph point delta coder
// Encodes one coordinate delta as none, one magnitude byte or two raw bytes.
// ----------------------------------------------------------------------------
module gpde_delta_coder (
  input  logic signed [gpde_pkg::COORD_W-1:0] cur,
  input  logic signed [gpde_pkg::COORD_W-1:0] base,
  output gpde_pkg::delta_code_t               code
);
  import gpde_pkg::*;

  logic signed [COORD_W:0] delta;
  logic signed [COORD_W:0] neg_delta;
  logic                    zero;
  logic                    fits;

  assign delta     = {cur[COORD_W-1], cur} - {base[COORD_W-1], base};
  assign neg_delta = -delta;
  assign zero      = (delta == '0);
  assign fits      = (delta >= -SHORT_LIMIT) && (delta <= SHORT_LIMIT);

  always_comb begin
    code = '0;
    if (zero) begin
      code.count   = CNT_NONE;
      code.is_same = 1'b1;
    end else if (fits) begin
      code.count      = CNT_ONE;
      code.is_short   = 1'b1;
      code.is_same    = ~delta[COORD_W];
      code.first_byte = delta[COORD_W] ? neg_delta[7:0] : delta[7:0];
    end else begin
      // wrap to 16 bits, big-endian
      code.count       = CNT_TWO;
      code.first_byte  = delta[15:8];
      code.second_byte = delta[7:0];
    end
  end

endmodule

[hw/rtl/gpde_axis_state.sv]
// ----------------------------------------------------------------------------
// Glyph point axis state
// Holds previous coordinate and running min/max for one axis.
// ----------------------------------------------------------------------------
module gpde_axis_state (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                first_point,
  input  logic signed [gpde_pkg::COORD_W-1:0] coord,
  output gpde_pkg::axis_view_t                view
);
  import gpde_pkg::*;

  logic signed [COORD_W-1:0] prev_r, prev_nxt;
  logic signed [COORD_W-1:0] least_r, least_nxt;
  logic signed [COORD_W-1:0] greatest_r, greatest_nxt;
  logic signed [COORD_W-1:0] lo_start;
  logic signed [COORD_W-1:0] hi_start;

  // restart the box and origin on a new glyph
  assign lo_start = first_point ? COORD_MAX : least_r;
  assign hi_start = first_point ? COORD_MIN : greatest_r;

  always_comb begin
    view.base = first_point ? '0 : prev_r;
    view.lo   = (coord < lo_start) ? coord : lo_start;
    view.hi   = (coord > hi_start) ? coord : hi_start;
  end

  assign prev_nxt     = advance ? coord   : prev_r;
  assign least_nxt    = advance ? view.lo : least_r;
  assign greatest_nxt = advance ? view.hi : greatest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      least_r    <= COORD_MAX;
      greatest_r <= COORD_MIN;
    end else begin
      prev_r     <= prev_nxt;
      least_r    <= least_nxt;
      greatest_r <= greatest_nxt;
    end
  end

endmodule
